// ===== sv/avf_pkg.sv =====
// shared types, constants and helper functions for the anemometer/vane front end
// no dependencies
package avf_pkg;

  localparam int AVG_SLOTS_DEF = 60;
  localparam int DIV_W         = 39;  // clicks * scale * 100 fits in 39 bits
  localparam int SPD_W         = 16;

  localparam logic [1:0] CFG_WIND_ENABLE = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_MS = 2'd1;
  localparam logic [1:0] CFG_CLICK_SCALE = 2'd2;

  localparam logic [4:0] DIR_UNKNOWN = 5'd16;

  typedef struct packed {
    logic        check;
    logic [11:0] vane_code;
    logic [5:0]  second_slot;
    logic [5:0]  minute_slot;
    logic        close_minute;
    logic        close_hour;
    logic        taken;
    logic [15:0] click_count;
    logic [15:0] ms_check;
  } q_entry_t;

  // vane windows in hundredths of a volt, first match wins
  localparam logic [8:0] WIN_LO [16] = '{9'd380, 9'd335, 9'd440, 9'd400, 9'd475, 9'd285,
                                         9'd295, 9'd100, 9'd120, 9'd40, 9'd65, 9'd10,
                                         9'd25, 9'd20, 9'd210, 9'd185};
  localparam logic [8:0] WIN_HI [16] = '{9'd395, 9'd360, 9'd450, 9'd415, 9'd500, 9'd295,
                                         9'd335, 9'd115, 9'd135, 9'd50, 9'd85, 9'd15,
                                         9'd34, 9'd25, 9'd222, 9'd190};
  localparam logic [15:0] WIN_LO_OPEN = 16'b0000_0000_0100_0000;
  localparam logic [15:0] WIN_HI_OPEN = 16'b0010_0000_0100_0000;
  localparam logic [4:0] WIN_DIR [16] = '{5'd0, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10,
                                          5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3,
                                          5'd2, 5'd1};

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // exact compare of code*500 against bound*4095
  function automatic logic [4:0] vane_classify(input logic [11:0] code);
    logic [20:0] x;
    logic [20:0] lo;
    logic [20:0] hi;
    logic        ok_lo;
    logic        ok_hi;
    logic [4:0]  dir;
    x   = 21'(code) * 21'd500;
    dir = DIR_UNKNOWN;
    for (int i = 15; i >= 0; i--) begin
      lo    = 21'(WIN_LO[i]) * 21'd4095;
      hi    = 21'(WIN_HI[i]) * 21'd4095;
      ok_lo = WIN_LO_OPEN[i] ? (x > lo) : (x >= lo);
      ok_hi = WIN_HI_OPEN[i] ? (x < hi) : (x <= hi);
      if (ok_lo && ok_hi) begin
        dir = WIN_DIR[i];
      end
    end
    vane_classify = dir;
  endfunction

endpackage

// ===== sv/avf_front.sv =====
// front end: debounces reed switch edges, tracks elapsed time, builds queue words
// depends on avf_pkg
module avf_front import avf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_switch_edge,
  input  logic        in_check_now,
  input  logic [11:0] in_vane_code,
  input  logic [5:0]  in_second_slot,
  input  logic [5:0]  in_minute_slot,
  input  logic        in_close_minute,
  input  logic        in_close_hour,
  input  logic        wind_enable,
  input  logic [7:0]  debounce_ms,
  input  logic        q_full,
  output logic        q_push,
  output q_entry_t    q_word
);

  logic [15:0] click_count_r, click_count_nxt;
  logic [15:0] ms_click_r, ms_click_nxt;
  logic [15:0] ms_check_r, ms_check_nxt;
  logic        took;
  logic [15:0] cc_with_click;
  logic        chk;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    took          = wind_enable && in_switch_edge && (ms_click_r > 16'(debounce_ms));
    cc_with_click = took ? sat_inc16(click_count_r) : click_count_r;
    chk           = wind_enable && in_check_now;
    click_count_nxt = chk ? 16'd0 : cc_with_click;
    ms_click_nxt    = took ? 16'd1 : sat_inc16(ms_click_r);
    ms_check_nxt    = chk ? 16'd1 : sat_inc16(ms_check_r);

    q_word.check        = chk;
    q_word.vane_code    = in_vane_code;
    q_word.second_slot  = in_second_slot;
    q_word.minute_slot  = in_minute_slot;
    q_word.close_minute = wind_enable && in_close_minute;
    q_word.close_hour   = wind_enable && in_close_hour;
    q_word.taken        = took;
    q_word.click_count  = cc_with_click;
    q_word.ms_check     = ms_check_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_count_r <= 16'd0;
      ms_click_r    <= 16'hFFFF;
      ms_check_r    <= 16'd0;
    end else if (q_push && wind_enable) begin
      click_count_r <= click_count_nxt;
      ms_click_r    <= ms_click_nxt;
      ms_check_r    <= ms_check_nxt;
    end
  end

endmodule

// ===== sv/avf_queue.sv =====
// two-word queue between front and back end
// depends on avf_pkg
module avf_queue import avf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_word,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_word,
  output logic     empty
);

  q_entry_t    slot_r [2];
  logic        wptr_r;
  logic        rptr_r;
  logic [1:0]  cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_word = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/avf_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// no dependencies
module avf_div #(
  parameter int DW = 39,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, dv_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        rem_r  <= '0;
        quo_r  <= dividend;
        dv_r   <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? VW'(trial - {1'b0, dv_r}) : trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/avf_back.sv =====
// back end: speed divide, slot stores, slot averages, vane heading, result register
// depends on avf_pkg and avf_div
module avf_back import avf_pkg::*; #(
  parameter int AVG_SLOTS = AVG_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] clicks_to_kph_milli,
  input  logic        q_empty,
  input  q_entry_t    q_word,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_speed_centikph,
  output logic [15:0] out_minute_avg_centikph,
  output logic [15:0] out_hour_avg_centikph,
  output logic [4:0]  out_direction,
  output logic        out_click_taken
);

  localparam int AW   = $clog2(AVG_SLOTS);
  localparam int IW   = $clog2(AVG_SLOTS + 1);
  localparam int SUMW = SPD_W + IW;
  // floor(sum / AVG_SLOTS) as a multiply by a rounded-up reciprocal
  localparam int RSH  = SUMW + $clog2(AVG_SLOTS);
  localparam int PW   = 2 * SUMW + 1;
  localparam logic [SUMW:0] RECIP =
    (SUMW+1)'(((64'd1 << RSH) + 64'(AVG_SLOTS) - 64'd1) / 64'(AVG_SLOTS));

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SCALE, S_DIVSPD, S_STORE, S_SUM, S_DIVAVG, S_OUT
  } state_t;

  state_t       state_r;
  q_entry_t     ent_r;
  logic [31:0]  prod_r;
  logic [15:0]  spd_r;
  logic [SUMW-1:0] acc_r;
  logic [IW-1:0]   idx_r;
  logic         pend_r;
  logic         which_r;
  logic [15:0]  speed_now_r, min_avg_r, hour_avg_r;
  logic [4:0]   heading_r;
  logic         out_valid_r;
  logic [15:0]  out_speed_r, out_min_r, out_hour_r;
  logic [4:0]   out_dir_r;
  logic         out_taken_r;

  logic [15:0]  min_mem [AVG_SLOTS];
  logic [15:0]  hr_mem  [AVG_SLOTS];
  logic [AVG_SLOTS-1:0] min_vld_r, hr_vld_r;
  logic [15:0]  rd_min_r, rd_hr_r;
  logic         rv_min_r, rv_hr_r;
  logic [15:0]  rd_val;
  logic         min_we, hr_we;
  logic [AW-1:0] min_waddr, hr_waddr, raddr;

  logic            div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [15:0]     div_divisor;
  logic            div_done;
  logic [DIV_W-1:0] div_quot;
  logic [DIV_W-1:0] scaled;
  logic [PW-1:0]   avg_prod;
  logic [15:0]     avg_q;
  logic            out_free;

  avf_div #(.DW(DIV_W), .VW(16)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // clicks * scale * 100 as shift-adds
  assign scaled = (DIV_W'(prod_r) << 6) + (DIV_W'(prod_r) << 5) + (DIV_W'(prod_r) << 2);

  assign avg_prod = PW'(acc_r) * PW'(RECIP);
  assign avg_q    = avg_prod[RSH +: 16];

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign raddr    = idx_r[AW-1:0];
  assign rd_val   = which_r ? (rv_hr_r ? rd_hr_r : 16'd0) : (rv_min_r ? rd_min_r : 16'd0);

  always_comb begin
    div_start    = (state_r == S_SCALE);
    div_dividend = scaled;
    div_divisor  = ent_r.ms_check;
  end

  always_comb begin
    min_we    = (state_r == S_STORE) && (32'(ent_r.second_slot) < 32'(AVG_SLOTS));
    hr_we     = (state_r == S_STORE) && (32'(ent_r.minute_slot) < 32'(AVG_SLOTS));
    min_waddr = AW'(ent_r.second_slot);
    hr_waddr  = AW'(ent_r.minute_slot);
  end

  always_ff @(posedge clk) begin
    if (min_we) begin
      min_mem[min_waddr] <= spd_r;
    end
    if (hr_we) begin
      hr_mem[hr_waddr] <= spd_r;
    end
    rd_min_r <= min_mem[raddr];
    rd_hr_r  <= hr_mem[raddr];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_vld_r <= '0;
      hr_vld_r  <= '0;
      rv_min_r  <= 1'b0;
      rv_hr_r   <= 1'b0;
    end else begin
      if (min_we) begin
        min_vld_r[min_waddr] <= 1'b1;
      end
      if (hr_we) begin
        hr_vld_r[hr_waddr] <= 1'b1;
      end
      rv_min_r <= min_vld_r[raddr];
      rv_hr_r  <= hr_vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      speed_now_r <= 16'd0;
      min_avg_r   <= 16'd0;
      hour_avg_r  <= 16'd0;
      heading_r   <= DIR_UNKNOWN;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      which_r     <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ent_r <= q_word;
            spd_r <= 16'd0;
            idx_r <= '0;
            pend_r <= 1'b0;
            acc_r <= '0;
            which_r <= !q_word.close_minute;
            if (q_word.check) begin
              state_r <= (q_word.ms_check == 16'd0) ? S_STORE : S_MUL;
            end else if (q_word.close_minute || q_word.close_hour) begin
              state_r <= S_SUM;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_MUL: begin
          prod_r  <= ent_r.click_count * clicks_to_kph_milli;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          state_r <= S_DIVSPD;
        end
        S_DIVSPD: begin
          if (div_done) begin
            spd_r   <= (div_quot[DIV_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          speed_now_r <= spd_r;
          heading_r   <= vane_classify(ent_r.vane_code);
          state_r     <= (ent_r.close_minute || ent_r.close_hour) ? S_SUM : S_OUT;
        end
        S_SUM: begin
          if (pend_r) begin
            acc_r <= acc_r + SUMW'(rd_val);
          end
          if (idx_r != IW'(AVG_SLOTS)) begin
            idx_r  <= idx_r + IW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_DIVAVG;
            end
          end
        end
        S_DIVAVG: begin
          if (which_r) begin
            hour_avg_r <= avg_q;
            state_r    <= S_OUT;
          end else begin
            min_avg_r <= avg_q;
            if (ent_r.close_hour) begin
              which_r <= 1'b1;
              idx_r   <= '0;
              pend_r  <= 1'b0;
              acc_r   <= '0;
              state_r <= S_SUM;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_speed_r <= speed_now_r;
            out_min_r   <= min_avg_r;
            out_hour_r  <= hour_avg_r;
            out_dir_r   <= heading_r;
            out_taken_r <= ent_r.taken;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_speed_centikph      = out_speed_r;
  assign out_minute_avg_centikph = out_min_r;
  assign out_hour_avg_centikph   = out_hour_r;
  assign out_direction           = out_dir_r;
  assign out_click_taken         = out_taken_r;

endmodule

// ===== sv/anemometer_vane_frontend_core.sv =====
// a check tick runs a serial 39-step divider, unless no time has elapsed; each close adds a
// walk of all AVG_SLOTS slots and a reciprocal multiply; one tick is worked at a time, the queue
// holds two more
// reset (synchronous, rst_n low): counters cleared, debounce timer at its maximum, slot stores
// read as zero, heading unknown, enable 1, debounce 10, scale 2401
module anemometer_vane_frontend_core import avf_pkg::*; #(
  parameter int AVG_SLOTS = AVG_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_switch_edge,
  input  logic        in_check_now,
  input  logic [11:0] in_vane_code,
  input  logic [5:0]  in_second_slot,
  input  logic [5:0]  in_minute_slot,
  input  logic        in_close_minute,
  input  logic        in_close_hour,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_speed_centikph,
  output logic [15:0] out_minute_avg_centikph,
  output logic [15:0] out_hour_avg_centikph,
  output logic [4:0]  out_direction,
  output logic        out_click_taken
);

  logic        wind_enable_r;
  logic [7:0]  debounce_ms_r;
  logic [15:0] click_scale_r;
  logic        q_full, q_empty, q_push, q_pop;
  q_entry_t    q_in_word, q_out_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_enable_r <= 1'b1;
      debounce_ms_r <= 8'd10;
      click_scale_r <= 16'd2401;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIND_ENABLE: wind_enable_r <= cfg_wdata[0];
        CFG_DEBOUNCE_MS: debounce_ms_r <= cfg_wdata[7:0];
        CFG_CLICK_SCALE: click_scale_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  avf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_switch_edge  (in_switch_edge),
    .in_check_now    (in_check_now),
    .in_vane_code    (in_vane_code),
    .in_second_slot  (in_second_slot),
    .in_minute_slot  (in_minute_slot),
    .in_close_minute (in_close_minute),
    .in_close_hour   (in_close_hour),
    .wind_enable     (wind_enable_r),
    .debounce_ms     (debounce_ms_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_word          (q_in_word)
  );

  avf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_out_word),
    .empty     (q_empty)
  );

  avf_back #(.AVG_SLOTS(AVG_SLOTS)) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .clicks_to_kph_milli     (click_scale_r),
    .q_empty                 (q_empty),
    .q_word                  (q_out_word),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_speed_centikph      (out_speed_centikph),
    .out_minute_avg_centikph (out_minute_avg_centikph),
    .out_hour_avg_centikph   (out_hour_avg_centikph),
    .out_direction           (out_direction),
    .out_click_taken         (out_click_taken)
  );

endmodule
